>>> sv/cisl_pkg.sv
// cisl_pkg: types and constants shared by the comment skipping integer lexer.
// No dependencies.
`timescale 1ns / 1ps

package cisl_pkg;

	localparam int OUT_W = 24;   // width of every result field but kind
	localparam int EXT_W = 48;   // width the counters are extended to before the result fields take their low bits

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [3:0] TAB_STOP = 4'd8;

	localparam logic KIND_INT     = 1'b0;
	localparam logic KIND_UNTERM  = 1'b1;

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_SLASH,
		MODE_LINE,
		MODE_BLOCK,
		MODE_STAR,
		MODE_DIGITS
	} mode_t;

	typedef struct packed {
		logic             kind;
		logic [OUT_W-1:0] line;
		logic [OUT_W-1:0] column;
		logic [OUT_W-1:0] offset;
		logic [OUT_W-1:0] count;
	} result_t;

endpackage

>>> sv/cisl_pos.sv
// cisl_pos: line, column and byte offset counters with saturation.
// Depends on cisl_pkg.
`timescale 1ns / 1ps

module cisl_pos #(
	parameter int CW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [7:0]    text_byte,
	input  logic          is_final,
	output logic [CW-1:0] cur_line,
	output logic [CW-1:0] cur_col,
	output logic [CW-1:0] cur_off,
	output logic [CW-1:0] nxt_line,
	output logic [CW-1:0] nxt_col,
	output logic [CW-1:0] nxt_off
);

	localparam logic [CW-1:0] ONE = CW'(1);

	logic [CW-1:0] line_q, col_q, off_q;
	logic [CW:0]   tab_sum;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] x);
		return (x == {CW{1'b1}}) ? x : x + ONE;
	endfunction

	assign cur_line = line_q;
	assign cur_col  = col_q;
	assign cur_off  = off_q;

	// next tab stop: col + 8 - col mod 8
	assign tab_sum = {1'b0, col_q}
		+ (CW+1)'(cisl_pkg::TAB_STOP - {1'b0, col_q[2:0]});

	always_comb begin
		nxt_line = line_q;
		nxt_off  = sat_inc(off_q);
		case (text_byte)
			cisl_pkg::CH_LF: begin
				nxt_line = sat_inc(line_q);
				nxt_col  = ONE;
			end
			cisl_pkg::CH_CR: nxt_col = ONE;
			cisl_pkg::CH_TAB: nxt_col = tab_sum[CW] ? {CW{1'b1}} : tab_sum[CW-1:0];
			default: nxt_col = sat_inc(col_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= ONE;
			col_q  <= ONE;
			off_q  <= '0;
		end else if (take) begin
			if (is_final) begin
				line_q <= ONE;
				col_q  <= ONE;
				off_q  <= '0;
			end else begin
				line_q <= nxt_line;
				col_q  <= nxt_col;
				off_q  <= nxt_off;
			end
		end
	end

endmodule

>>> sv/cisl_scan.sv
// cisl_scan: comment and digit-run scanner; decides the result of each byte.
// Depends on cisl_pkg; takes positions from cisl_pos.
`timescale 1ns / 1ps

module cisl_scan #(
	parameter int CW = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        text_byte,
	input  logic              is_final,
	input  logic [CW-1:0]     cur_line,
	input  logic [CW-1:0]     cur_col,
	input  logic [CW-1:0]     cur_off,
	input  logic [CW-1:0]     nxt_line,
	input  logic [CW-1:0]     nxt_col,
	input  logic [CW-1:0]     nxt_off,
	output logic              emit,
	output cisl_pkg::result_t res
);

	localparam int EXT_W = cisl_pkg::EXT_W;

	cisl_pkg::mode_t mode_q, mode_nx;
	logic [CW-1:0] rs_line_q, rs_col_q, rs_off_q, rlen_q;
	logic [CW-1:0] rs_line_nx, rs_col_nx, rs_off_nx, rlen_nx;
	logic          is_dig, start_run, end_run;
	logic [EXT_W-1:0] e_line, e_col, e_off, e_cnt;

	assign is_dig = (text_byte >= cisl_pkg::CH_ZERO) && (text_byte <= cisl_pkg::CH_NINE);

	function automatic cisl_pkg::mode_t scan_plain(input logic [7:0] c, input logic dig);
		if (c == cisl_pkg::CH_SLASH) return cisl_pkg::MODE_SLASH;
		else if (dig) return cisl_pkg::MODE_DIGITS;
		else return cisl_pkg::MODE_NORMAL;
	endfunction

	// next state
	always_comb begin
		unique case (mode_q)
			cisl_pkg::MODE_SLASH: begin
				if (text_byte == cisl_pkg::CH_SLASH) mode_nx = cisl_pkg::MODE_LINE;
				else if (text_byte == cisl_pkg::CH_STAR) mode_nx = cisl_pkg::MODE_BLOCK;
				else mode_nx = scan_plain(text_byte, is_dig);
			end
			cisl_pkg::MODE_LINE:
				mode_nx = (text_byte == cisl_pkg::CH_LF) ? cisl_pkg::MODE_NORMAL
				                                          : cisl_pkg::MODE_LINE;
			cisl_pkg::MODE_BLOCK:
				mode_nx = (text_byte == cisl_pkg::CH_STAR) ? cisl_pkg::MODE_STAR
				                                            : cisl_pkg::MODE_BLOCK;
			cisl_pkg::MODE_STAR: begin
				if (text_byte == cisl_pkg::CH_SLASH) mode_nx = cisl_pkg::MODE_NORMAL;
				else if (text_byte == cisl_pkg::CH_STAR) mode_nx = cisl_pkg::MODE_STAR;
				else mode_nx = cisl_pkg::MODE_BLOCK;
			end
			cisl_pkg::MODE_DIGITS:
				mode_nx = is_dig ? cisl_pkg::MODE_DIGITS : scan_plain(text_byte, is_dig);
			default: mode_nx = scan_plain(text_byte, is_dig);
		endcase
	end

	// outputs
	always_comb begin
		start_run = 1'b0;
		end_run   = 1'b0;
		unique case (mode_q)
			cisl_pkg::MODE_NORMAL: start_run = is_dig;
			cisl_pkg::MODE_SLASH:
				start_run = is_dig && (text_byte != cisl_pkg::CH_SLASH)
				            && (text_byte != cisl_pkg::CH_STAR);
			cisl_pkg::MODE_DIGITS: begin
				end_run   = !is_dig;
				start_run = 1'b0;
			end
			default: start_run = 1'b0;
		endcase
	end

	always_comb begin
		rs_line_nx = rs_line_q;
		rs_col_nx  = rs_col_q;
		rs_off_nx  = rs_off_q;
		rlen_nx    = rlen_q;
		if (start_run) begin
			rs_line_nx = cur_line;
			rs_col_nx  = cur_col;
			rs_off_nx  = cur_off;
			rlen_nx    = CW'(1);
		end else if (mode_q == cisl_pkg::MODE_DIGITS && is_dig && rlen_q != {CW{1'b1}}) begin
			rlen_nx = rlen_q + CW'(1);
		end
	end

	// result: a run closed by this byte wins; otherwise end of text may report
	always_comb begin
		emit     = 1'b0;
		res.kind = cisl_pkg::KIND_INT;
		e_line   = EXT_W'(rs_line_nx);
		e_col    = EXT_W'(rs_col_nx);
		e_off    = EXT_W'(rs_off_nx);
		e_cnt    = EXT_W'(rlen_nx);
		if (end_run) begin
			emit   = 1'b1;
			e_line = EXT_W'(rs_line_q);
			e_col  = EXT_W'(rs_col_q);
			e_off  = EXT_W'(rs_off_q);
			e_cnt  = EXT_W'(rlen_q);
		end else if (is_final) begin
			if (mode_nx == cisl_pkg::MODE_BLOCK || mode_nx == cisl_pkg::MODE_STAR) begin
				emit     = 1'b1;
				res.kind = cisl_pkg::KIND_UNTERM;
				e_line   = EXT_W'(nxt_line);
				e_col    = EXT_W'(nxt_col);
				e_off    = EXT_W'(nxt_off);
				e_cnt    = '0;
			end else if (mode_nx == cisl_pkg::MODE_DIGITS) begin
				emit = 1'b1;
			end
		end
		res.line   = e_line[cisl_pkg::OUT_W-1:0];
		res.column = e_col[cisl_pkg::OUT_W-1:0];
		res.offset = e_off[cisl_pkg::OUT_W-1:0];
		res.count  = e_cnt[cisl_pkg::OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= cisl_pkg::MODE_NORMAL;
			rs_line_q <= '0;
			rs_col_q  <= '0;
			rs_off_q  <= '0;
			rlen_q    <= '0;
		end else if (take) begin
			if (is_final) begin
				mode_q    <= cisl_pkg::MODE_NORMAL;
				rs_line_q <= '0;
				rs_col_q  <= '0;
				rs_off_q  <= '0;
				rlen_q    <= '0;
			end else begin
				mode_q    <= mode_nx;
				rs_line_q <= rs_line_nx;
				rs_col_q  <= rs_col_nx;
				rs_off_q  <= rs_off_nx;
				rlen_q    <= rlen_nx;
			end
		end
	end

endmodule

>>> sv/comment_skipping_integer_lexer_top.sv
// comment_skipping_integer_lexer_top: streaming integer lexer with comment skipping.
// Depends on cisl_pkg, cisl_pos and cisl_scan.
`timescale 1ns / 1ps

// One source byte is taken per clock; a token or error appears on the output
// register the cycle after the byte that produces it, and the input keeps
// flowing while that result waits, stalling only when a held result is not
// taken. Throughput is one byte per cycle, set by the single scanner/position
// update between the state registers and the result register. Whitespace,
// line and block comments produce nothing; a digit run yields one token when
// it ends; end of text inside a block comment yields an error. All counters
// saturate at 2^COUNTER_WIDTH-1, and the result fields carry their low 24 bits.
module comment_skipping_integer_lexer_top #(
	parameter int COUNTER_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        is_final,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [23:0] start_line,
	output logic [23:0] start_column,
	output logic [23:0] start_offset,
	output logic [23:0] digit_count
);

	localparam int CW = COUNTER_WIDTH;

	logic              take, emit;
	logic [CW-1:0]     cur_line, cur_col, cur_off, nxt_line, nxt_col, nxt_off;
	cisl_pkg::result_t res, res_q;
	logic              out_valid_q;

	assign in_stall = out_valid_q && out_stall;
	assign take     = in_valid && !in_stall;

	cisl_pos #(.CW(CW)) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.text_byte (text_byte),
		.is_final  (is_final),
		.cur_line  (cur_line),
		.cur_col   (cur_col),
		.cur_off   (cur_off),
		.nxt_line  (nxt_line),
		.nxt_col   (nxt_col),
		.nxt_off   (nxt_off)
	);

	cisl_scan #(.CW(CW)) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.text_byte (text_byte),
		.is_final  (is_final),
		.cur_line  (cur_line),
		.cur_col   (cur_col),
		.cur_off   (cur_off),
		.nxt_line  (nxt_line),
		.nxt_col   (nxt_col),
		.nxt_off   (nxt_off),
		.emit      (emit),
		.res       (res)
	);

	// result register: reloads whenever a byte is taken, drains on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = res_q.kind;
	assign start_line   = res_q.line;
	assign start_column = res_q.column;
	assign start_offset = res_q.offset;
	assign digit_count  = res_q.count;

endmodule

>>> sv/cisl_chk.sv
// cisl_chk: port-level checks on the lexer top, bound to every instance.
// Depends on cisl_pkg and comment_skipping_integer_lexer_top.
`timescale 1ns / 1ps

module cisl_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        kind,
	input logic [23:0] start_line,
	input logic [23:0] start_column,
	input logic [23:0] start_offset,
	input logic [23:0] digit_count
);

	// a held result stays put until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(start_line)
			&& $stable(start_column) && $stable(start_offset) && $stable(digit_count))
		else $error("held result changed");

	// input only backs up behind a waiting result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// no result appears without a byte taken the cycle before
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !(in_valid && !in_stall) |=> !out_valid)
		else $error("result without input");

	a_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == cisl_pkg::KIND_UNTERM |-> digit_count == 24'd0)
		else $error("error result with nonzero digit count");

endmodule

bind comment_skipping_integer_lexer_top cisl_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.kind         (kind),
	.start_line   (start_line),
	.start_column (start_column),
	.start_offset (start_offset),
	.digit_count  (digit_count)
);

>>> sim/tb_top.sv
// tb_top: self-checking testbench for comment_skipping_integer_lexer_top.
// Drives source text byte by byte, predicts tokens and errors, and compares each result.
// Depends on cisl_pkg and comment_skipping_integer_lexer_top.
`timescale 1ns / 1ps

module tb_top;

	localparam int OUT_W = cisl_pkg::OUT_W;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [7:0]       text_byte = 8'h00;
	logic             is_final = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             kind;
	logic [OUT_W-1:0] start_line;
	logic [OUT_W-1:0] start_column;
	logic [OUT_W-1:0] start_offset;
	logic [OUT_W-1:0] digit_count;

	comment_skipping_integer_lexer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.is_final(is_final),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.start_line(start_line),
		.start_column(start_column),
		.start_offset(start_offset),
		.digit_count(digit_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// lexer state as predicted
	cisl_pkg::mode_t  lex_mode;
	logic [OUT_W-1:0] cur_line, cur_col, cur_off;
	logic [OUT_W-1:0] run_line, run_col, run_off, run_len;

	cisl_pkg::result_t expected_tokens[$];
	logic [7:0] text_buf[$];
	int         mismatch_count = 0;
	int         items_sent = 0;
	int         burst_left = 0;
	int         gap_max = 0;
	int         stall_pct = 0;
	int         stall_left = 0;
	bit         stall_now = 1'b0;

	function automatic logic [OUT_W-1:0] sat_add(logic [OUT_W-1:0] a, logic [OUT_W-1:0] b);
		logic [OUT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[OUT_W] ? {OUT_W{1'b1}} : s[OUT_W-1:0];
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= cisl_pkg::CH_ZERO && c <= cisl_pkg::CH_NINE;
	endfunction

	function automatic void lexer_restart();
		lex_mode = cisl_pkg::MODE_NORMAL;
		cur_line = 1;
		cur_col = 1;
		cur_off = 0;
		run_line = 0;
		run_col = 0;
		run_off = 0;
		run_len = 0;
	endfunction

	// byte seen outside any comment or run; ln/col/off are its own position
	function automatic void scan_plain(logic [7:0] c, logic [OUT_W-1:0] ln,
			logic [OUT_W-1:0] col, logic [OUT_W-1:0] off);
		if (c == cisl_pkg::CH_SLASH) begin
			lex_mode = cisl_pkg::MODE_SLASH;
		end else if (is_digit(c)) begin
			lex_mode = cisl_pkg::MODE_DIGITS;
			run_line = ln;
			run_col = col;
			run_off = off;
			run_len = 1;
		end else begin
			lex_mode = cisl_pkg::MODE_NORMAL;
		end
	endfunction

	function automatic void lex_byte(logic [7:0] c, logic fin);
		logic [OUT_W-1:0]  ln, col, off;
		bit                hit;
		cisl_pkg::result_t tok;
		ln = cur_line;
		col = cur_col;
		off = cur_off;
		hit = 1'b0;
		tok = '0;
		case (lex_mode)
			cisl_pkg::MODE_SLASH: begin
				if (c == cisl_pkg::CH_SLASH)
					lex_mode = cisl_pkg::MODE_LINE;
				else if (c == cisl_pkg::CH_STAR)
					lex_mode = cisl_pkg::MODE_BLOCK;
				else
					scan_plain(c, ln, col, off);
			end
			cisl_pkg::MODE_LINE: begin
				if (c == cisl_pkg::CH_LF)
					lex_mode = cisl_pkg::MODE_NORMAL;
			end
			cisl_pkg::MODE_BLOCK: begin
				if (c == cisl_pkg::CH_STAR)
					lex_mode = cisl_pkg::MODE_STAR;
			end
			cisl_pkg::MODE_STAR: begin
				if (c == cisl_pkg::CH_SLASH)
					lex_mode = cisl_pkg::MODE_NORMAL;
				else if (c != cisl_pkg::CH_STAR)
					lex_mode = cisl_pkg::MODE_BLOCK;
			end
			cisl_pkg::MODE_DIGITS: begin
				if (is_digit(c)) begin
					run_len = sat_add(run_len, 1);
				end else begin
					tok = '{cisl_pkg::KIND_INT, run_line, run_col, run_off, run_len};
					hit = 1'b1;
					scan_plain(c, ln, col, off);
				end
			end
			default: scan_plain(c, ln, col, off);
		endcase

		if (c == cisl_pkg::CH_LF) begin
			cur_line = sat_add(cur_line, 1);
			cur_col = 1;
		end else if (c == cisl_pkg::CH_CR) begin
			cur_col = 1;
		end else if (c == cisl_pkg::CH_TAB) begin
			cur_col = sat_add(cur_col, OUT_W'(cisl_pkg::TAB_STOP) - OUT_W'(cur_col[2:0]));
		end else begin
			cur_col = sat_add(cur_col, 1);
		end
		cur_off = sat_add(cur_off, 1);

		if (fin) begin
			if (!hit) begin
				if (lex_mode == cisl_pkg::MODE_BLOCK || lex_mode == cisl_pkg::MODE_STAR) begin
					tok = '{cisl_pkg::KIND_UNTERM, cur_line, cur_col, cur_off, OUT_W'(0)};
					hit = 1'b1;
				end else if (lex_mode == cisl_pkg::MODE_DIGITS) begin
					tok = '{cisl_pkg::KIND_INT, run_line, run_col, run_off, run_len};
					hit = 1'b1;
				end
			end
			lexer_restart();
		end
		if (hit)
			expected_tokens.push_back(tok);
	endfunction

	task automatic flag_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
		$display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		cisl_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_tokens.size() == 0) begin
				flag_mismatch("result with nothing expected", start_offset, 0);
			end else begin
				want = expected_tokens.pop_front();
				if (kind != want.kind)
					flag_mismatch("kind", OUT_W'(kind), OUT_W'(want.kind));
				if (start_line != want.line)
					flag_mismatch("start_line", start_line, want.line);
				if (start_column != want.column)
					flag_mismatch("start_column", start_column, want.column);
				if (start_offset != want.offset)
					flag_mismatch("start_offset", start_offset, want.offset);
				if (digit_count != want.count)
					flag_mismatch("digit_count", digit_count, want.count);
			end
		end
	end

	// receiver stall pattern: runs of stall / no stall, now and then a long stall
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_left = $urandom_range(12, 1);
			stall_now = ($urandom_range(99, 0) < stall_pct);
			if (stall_now && $urandom_range(15, 0) == 0)
				stall_left = $urandom_range(40, 20);
		end
		stall_left--;
		out_stall <= stall_now;
	end

	// one transfer; called and returns at a falling edge
	task automatic send_byte(logic [7:0] b, logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(16, 1);
			gap = $urandom_range(gap_max, 0);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		text_byte <= b;
		is_final <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		lex_byte(b, fin);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text();
		foreach (text_buf[i])
			send_byte(text_buf[i], i == text_buf.size() - 1);
	endtask

	// sender holds off until every expected result has been taken, or flags the ones that never arrive
	task automatic settle_results();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (expected_tokens.size() != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		if (expected_tokens.size() != 0) begin
			flag_mismatch("results never arrived", OUT_W'(expected_tokens.size()), 0);
			expected_tokens.delete();
		end
		repeat (8) @(negedge clk);
	endtask

	// well-formed text with random content; sometimes left open at the end
	function automatic void build_text();
		int pieces, sel, n;
		text_buf.delete();
		pieces = $urandom_range(12, 1);
		repeat (pieces) begin
			sel = $urandom_range(99, 0);
			if (sel < 30) begin
				n = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 6) : $urandom_range(5, 1);
				repeat (n) text_buf.push_back(cisl_pkg::CH_ZERO + 8'($urandom_range(9, 0)));
			end else if (sel < 50) begin
				case ($urandom_range(3, 0))
					0: text_buf.push_back(8'h20);
					1: text_buf.push_back(cisl_pkg::CH_TAB);
					2: text_buf.push_back(cisl_pkg::CH_CR);
					default: text_buf.push_back(cisl_pkg::CH_LF);
				endcase
			end else if (sel < 62) begin
				text_buf.push_back(cisl_pkg::CH_SLASH);
				text_buf.push_back(cisl_pkg::CH_SLASH);
				repeat ($urandom_range(8, 0)) text_buf.push_back(8'($urandom_range(255, 0)));
				text_buf.push_back(cisl_pkg::CH_LF);
			end else if (sel < 77) begin
				text_buf.push_back(cisl_pkg::CH_SLASH);
				text_buf.push_back(cisl_pkg::CH_STAR);
				repeat ($urandom_range(10, 0)) begin
					case ($urandom_range(4, 0))
						0: text_buf.push_back(cisl_pkg::CH_STAR);
						1: text_buf.push_back(cisl_pkg::CH_SLASH);
						2: text_buf.push_back(cisl_pkg::CH_LF);
						3: text_buf.push_back(cisl_pkg::CH_ZERO + 8'($urandom_range(9, 0)));
						default: text_buf.push_back(8'($urandom_range(255, 0)));
					endcase
				end
				text_buf.push_back(cisl_pkg::CH_STAR);
				text_buf.push_back(cisl_pkg::CH_SLASH);
			end else if (sel < 85) begin
				text_buf.push_back(cisl_pkg::CH_SLASH);
				if ($urandom_range(1, 0))
					text_buf.push_back(cisl_pkg::CH_ZERO + 8'($urandom_range(9, 0)));
				else
					text_buf.push_back(8'($urandom_range(8'h7E, 8'h61)));
			end else if (sel < 95) begin
				text_buf.push_back(8'($urandom_range(8'h7E, 8'h20)));
			end else begin
				text_buf.push_back(8'($urandom_range(255, 0)));
			end
		end
		// end of text inside a comment
		case ($urandom_range(7, 0))
			0: begin
				text_buf.push_back(cisl_pkg::CH_SLASH);
				text_buf.push_back(cisl_pkg::CH_STAR);
				repeat ($urandom_range(3, 0)) text_buf.push_back(8'($urandom_range(255, 0)));
			end
			1: begin
				text_buf.push_back(cisl_pkg::CH_SLASH);
				text_buf.push_back(cisl_pkg::CH_SLASH);
				text_buf.push_back(8'($urandom_range(255, 0)));
			end
			default: ;
		endcase
	endfunction

	task automatic test_directed();
		gap_max = 0;
		stall_pct = 0;
		// tab, run ended by a high byte, lone slash before a digit, slash as final byte
		text_buf = {cisl_pkg::CH_TAB, 8'h35, 8'hFF, cisl_pkg::CH_SLASH, 8'h33,
			cisl_pkg::CH_SLASH};
		send_text();
		// CR/LF, slash right after the opening stays in the comment, digit as final byte
		text_buf = {cisl_pkg::CH_CR, cisl_pkg::CH_LF, cisl_pkg::CH_SLASH, cisl_pkg::CH_STAR,
			cisl_pkg::CH_SLASH, cisl_pkg::CH_STAR, cisl_pkg::CH_SLASH, cisl_pkg::CH_NINE};
		send_text();
		// text ends in a line comment
		text_buf = {cisl_pkg::CH_SLASH, cisl_pkg::CH_SLASH, 8'h00};
		send_text();
		// text ends in a block comment, once after a star and once in the body
		text_buf = {cisl_pkg::CH_SLASH, cisl_pkg::CH_STAR, cisl_pkg::CH_STAR};
		send_text();
		text_buf = {cisl_pkg::CH_SLASH, cisl_pkg::CH_STAR, 8'h80};
		send_text();
		text_buf = {cisl_pkg::CH_ZERO};
		send_text();
		settle_results();
	endtask

	task automatic test_text_stream(int gaps, int stalls, int count);
		int target;
		gap_max = gaps;
		stall_pct = stalls;
		target = items_sent + count;
		while (items_sent < target) begin
			build_text();
			send_text();
		end
		settle_results();
	endtask

	task automatic test_noise(int count);
		gap_max = 3;
		stall_pct = 40;
		repeat (count)
			send_byte(8'($urandom_range(255, 0)), $urandom_range(29, 0) == 0);
		settle_results();
	endtask

	initial begin
		lexer_restart();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_text_stream(0, 0, 500);
		test_text_stream(6, 30, 550);
		test_text_stream(2, 75, 550);
		test_noise(330);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
sv/cisl_pkg.sv
sv/cisl_pos.sv
sv/cisl_scan.sv
sv/comment_skipping_integer_lexer_top.sv
sv/cisl_chk.sv
sim/tb_top.sv
